@@ hw/rtl/mbd_pkg.sv @@
// Shared types and codes for the mailbox ring deque.
package mbd_pkg;

   // Width of the capacity register and of the fill count
   localparam int CNT_W = 5;
   // Width of the message word on the channels
   localparam int PORT_MSG_W = 32;

   typedef enum logic [1:0] {
      KIND_POST_BACK  = 2'd0,
      KIND_POST_FRONT = 2'd1,
      KIND_TAKE       = 2'd2,
      KIND_FLUSH      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   // Slot memory access strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

@@ hw/rtl/mbd_ram.sv @@
// Slot memory: one write port, one read port with registered read data.
module mbd_ram #(
   parameter int DEPTH     = 16,
   parameter int MSG_WIDTH = 32
) (
   input  logic                     clock,
   input  mbd_pkg::mem_ctl_type     mem_ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [MSG_WIDTH-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [MSG_WIDTH-1:0]     rd_data
);

   logic [MSG_WIDTH-1:0] slot_ff [DEPTH];
   logic [MSG_WIDTH-1:0] rd_data_ff;

   // Write the slot on a post
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
   end

   // Read the slot on a take; hold the data until the next read
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= slot_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mbd_ctrl.sv @@
// Ring control: capacity register, indices, count, sequencing and result register.
module mbd_ctrl #(
   parameter int DEPTH     = 16,
   parameter int MSG_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_kind,
   input  logic [mbd_pkg::PORT_MSG_W-1:0]     req_message,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [mbd_pkg::PORT_MSG_W-1:0]     rsp_message_out,
   output logic [mbd_pkg::CNT_W-1:0]          rsp_fill_count,
   // capacity register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbd_pkg::CNT_W-1:0]          csr_capacity,
   // slot memory
   output mbd_pkg::mem_ctl_type               mem_ctl,
   output logic [$clog2(DEPTH)-1:0]           wr_addr,
   output logic [MSG_WIDTH-1:0]               wr_data,
   output logic [$clog2(DEPTH)-1:0]           rd_addr,
   input  logic [MSG_WIDTH-1:0]               rd_data
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CW      = mbd_pkg::CNT_W;
   localparam int CMP_W   = (IDX_W + 1 > CW) ? IDX_W + 1 : CW;
   localparam int CAP_MAX = (1 << CW) - 1;
   localparam int CAP_RST = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

   mbd_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        capacity_ff;
   logic [IDX_W-1:0]     head_ff, head_in, head_nx;
   logic [IDX_W-1:0]     tail_ff, tail_in, tail_nx;
   logic [CW-1:0]        held_ff, held_in, held_nx;
   logic [CW-1:0]        pend_fill_ff, pend_fill_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [mbd_pkg::PORT_MSG_W-1:0] rsp_message_ff, rsp_message_in;
   logic [CW-1:0]        rsp_fill_ff, rsp_fill_in;

   logic [CMP_W-1:0]     cap_ext, eff_cap;
   logic [CMP_W-1:0]     head_inc, tail_inc;
   logic [IDX_W-1:0]     head_adv, tail_adv, head_prev;
   logic                 is_full, is_empty;
   logic                 out_free, req_fire;
   logic                 go_read;
   mbd_pkg::kind_type    kind;
   mbd_pkg::status_type  res_status;
   mbd_pkg::mem_ctl_type mem_nx;

   assign kind      = mbd_pkg::kind_type'(req_kind);
   assign csr_ready = 1'b1;

   // Clamp the capacity into 1..DEPTH
   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // Index arithmetic with wrap at the capacity
   assign head_inc  = CMP_W'(head_ff) + CMP_W'(1);
   assign tail_inc  = CMP_W'(tail_ff) + CMP_W'(1);
   assign head_adv  = (head_inc >= eff_cap) ? '0 : IDX_W'(head_inc);
   assign tail_adv  = (tail_inc >= eff_cap) ? '0 : IDX_W'(tail_inc);
   assign head_prev = (head_ff == '0) ? IDX_W'(eff_cap - CMP_W'(1)) : head_ff - IDX_W'(1);
   assign is_full   = CMP_W'(held_ff) >= eff_cap;
   assign is_empty  = held_ff == '0;

   // Accept while idle and the result register is free or draining
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mbd_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   // Decode the operation
   always_comb begin
      head_nx    = head_ff;
      tail_nx    = tail_ff;
      held_nx    = held_ff;
      res_status = mbd_pkg::STAT_DONE;
      mem_nx     = '0;
      wr_addr    = tail_ff;
      go_read    = 1'b0;
      unique case (kind)
         mbd_pkg::KIND_POST_BACK: begin
            if (is_full) begin
               res_status = mbd_pkg::STAT_FULL;
            end else begin
               mem_nx.wr_en = 1'b1;
               wr_addr      = tail_ff;
               tail_nx      = tail_adv;
               held_nx      = held_ff + CW'(1);
            end
         end
         mbd_pkg::KIND_POST_FRONT: begin
            if (is_full) begin
               res_status = mbd_pkg::STAT_FULL;
            end else begin
               mem_nx.wr_en = 1'b1;
               wr_addr      = head_prev;
               head_nx      = head_prev;
               held_nx      = held_ff + CW'(1);
            end
         end
         mbd_pkg::KIND_TAKE: begin
            if (is_empty) begin
               res_status = mbd_pkg::STAT_EMPTY;
            end else begin
               mem_nx.rd_en = 1'b1;
               go_read      = 1'b1;
               head_nx      = head_adv;
               held_nx      = held_ff - CW'(1);
            end
         end
         mbd_pkg::KIND_FLUSH: begin
            head_nx = '0;
            tail_nx = '0;
            held_nx = '0;
         end
         default: begin
            res_status = mbd_pkg::STAT_DONE;
         end
      endcase
   end

   // Drive the memory only on a transfer
   assign mem_ctl.wr_en = mem_nx.wr_en && req_fire;
   assign mem_ctl.rd_en = mem_nx.rd_en && req_fire;
   assign wr_data       = MSG_WIDTH'(req_message);
   assign rd_addr       = head_ff;

   // Advance ring state on a transfer
   assign head_in      = req_fire ? head_nx : head_ff;
   assign tail_in      = req_fire ? tail_nx : tail_ff;
   assign held_in      = req_fire ? held_nx : held_ff;
   assign pend_fill_in = (req_fire && go_read) ? held_nx : pend_fill_ff;

   // Sequence: a take waits in ST_READ for the slot data and a free result register
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbd_pkg::ST_IDLE: begin
            if (req_fire && go_read) begin
               state_in = mbd_pkg::ST_READ;
            end
         end
         mbd_pkg::ST_READ: begin
            if (out_free) begin
               state_in = mbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbd_pkg::ST_IDLE;
         end
      endcase
   end

   // Load or drain the result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_message_in = rsp_message_ff;
      rsp_fill_in    = rsp_fill_ff;
      if (state_ff == mbd_pkg::ST_READ && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = mbd_pkg::STAT_DONE;
         rsp_message_in = mbd_pkg::PORT_MSG_W'(rd_data);
         rsp_fill_in    = pend_fill_ff;
      end else if (req_fire && !go_read) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_message_in = '0;
         rsp_fill_in    = held_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbd_pkg::ST_IDLE;
         capacity_ff  <= CW'(CAP_RST);
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_fill_ff   <= pend_fill_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_message_ff <= rsp_message_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_message_out = rsp_message_ff;
   assign rsp_fill_count  = rsp_fill_ff;

   // The slot memory is never written and read in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("slot memory written and read in one cycle");

   // A take of a held message waits for the slot data
   a_take_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire && kind == mbd_pkg::KIND_TAKE && !is_empty |=> state_ff == mbd_pkg::ST_READ)
      else $error("take did not enter the read wait");

   // A flush reports an empty ring
   a_flush_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && kind == mbd_pkg::KIND_FLUSH |=> rsp_valid_ff && rsp_fill_ff == '0
      && held_ff == '0)
      else $error("flush left messages counted");

   // The count never exceeds the built depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(held_ff) <= CMP_W'(DEPTH))
      else $error("held count beyond depth");

endmodule

@@ hw/rtl/mailbox_ring_deque.sv @@
// Top level of the mailbox ring deque.
//
// A bounded ring of message words that takes posts at both ends and takes from the front.
// Request channel (req_): kind selects post to back, post to front, take or flush;
// req_message carries the word for a post. Each request transfer gives exactly one
// result transfer on the rsp_ channel: status (done, empty on take, full on post), the
// word taken by a successful take (zero otherwise) and the count held afterward.
// Configuration (csr_): one write-only register, the capacity in slots, clamped to
// 1..DEPTH; write it only while no request is outstanding. csr_ready is always high.
// A post, a failed take or a flush loads the result register in the cycle after the
// transfer; a successful take reads the slot into the memory's read register, then
// loads the result register once it is free. Throughput: one post or flush per cycle
// while results drain; a successful take holds the request side while the slot is read.
// A stalled receiver holds the result register; the next request is taken in the cycle
// that register drains. Reset is synchronous: it empties the ring and sets the capacity
// to min(DEPTH, 31). Slot contents are not cleared; no slot is read before it was written.
module mailbox_ring_deque #(
   parameter int DEPTH     = 16,
   parameter int MSG_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [mbd_pkg::PORT_MSG_W-1:0] req_message,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [mbd_pkg::PORT_MSG_W-1:0] rsp_message_out,
   output logic [mbd_pkg::CNT_W-1:0]      rsp_fill_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mbd_pkg::CNT_W-1:0]      csr_capacity
);

   localparam int IDX_W = $clog2(DEPTH);

   mbd_pkg::mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [MSG_WIDTH-1:0] wr_data;
   logic [MSG_WIDTH-1:0] rd_data;

   mbd_ctrl #(
      .DEPTH     (DEPTH),
      .MSG_WIDTH (MSG_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_message     (req_message),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_message_out (rsp_message_out),
      .rsp_fill_count  (rsp_fill_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity),
      .mem_ctl         (mem_ctl),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   mbd_ram #(
      .DEPTH     (DEPTH),
      .MSG_WIDTH (MSG_WIDTH)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
